// ===== hdl/mie_pkg.sv =====
package mie_pkg;

    // Word width that sets the round bound of the Euclid loop.
    localparam int WORD_BITS   = 32;
    localparam int ROUND_LIMIT = 2 * WORD_BITS + 8;
    localparam int ROUND_W     = $clog2(ROUND_LIMIT + 1);

    // Operand width and the width of the signed Bezout coefficients.
    localparam int DATA_W = 31;
    localparam int S_W    = DATA_W + 2;
    localparam int DCNT_W = $clog2(DATA_W + 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOINV   = 2'd1,
        ST_MODZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] modulus;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] inverse;
        status_t           status;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_UPD,
        S_FIN1,
        S_FIN2,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic mul;
        logic upd;
        logic fin_norm;
        logic fin_fix;
        logic result_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic r_zero;
        logic div_busy;
        logic round_max;
    } dp_stat_t;

endpackage

// ===== hdl/mie_div.sv =====
module mie_div
    import mie_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [DATA_W+1:0] trial;

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign trial = {1'b0, rem_reg, quo_reg[DATA_W-1]} - {2'b00, dsr_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = DCNT_W'(DATA_W);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[DATA_W+1])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    // The step counter is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/mie_datapath.sv =====
module mie_datapath
    import mie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_t      in_data,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output out_t     out_data
);

    logic [DATA_W-1:0]        r_prev_reg, r_prev_next;
    logic [DATA_W-1:0]        r_cur_reg, r_cur_next;
    logic [DATA_W-1:0]        mod_reg, mod_next;
    logic signed [S_W-1:0]    s_prev_reg, s_prev_next;
    logic signed [S_W-1:0]    s_cur_reg, s_cur_next;
    logic signed [S_W:0]      prod_reg, prod_next;
    logic [DATA_W-1:0]        x_reg, x_next;
    logic [DATA_W-1:0]        inv_reg, inv_next;
    status_t                  st_reg, st_next;
    out_t                     out_reg, out_next;
    logic [ROUND_W-1:0]       rounds_reg, rounds_next;

    logic                     div_busy;
    logic [DATA_W-1:0]        div_quo;
    logic [DATA_W-1:0]        div_rem;
    logic signed [DATA_W:0]   q_s;
    logic signed [DATA_W+S_W:0] prod_full;
    logic signed [S_W:0]      s_diff;
    logic [S_W-1:0]           x_sum;

    // Shared divider for the quotient and remainder of each round.
    mie_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (r_prev_reg),
        .divisor   (r_cur_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Coefficient product q * s_cur; it is registered before the subtract.
    assign q_s       = $signed({1'b0, div_quo});
    assign prod_full = q_s * s_cur_reg;
    assign s_diff    = $signed({s_prev_reg[S_W-1], s_prev_reg}) - prod_reg;

    // A negative coefficient is brought into range by adding the modulus.
    assign x_sum = s_prev_reg + (s_prev_reg[S_W-1] ? {2'b00, mod_reg} : {S_W{1'b0}});

    always_comb
    begin
        r_prev_next = r_prev_reg;
        r_cur_next  = r_cur_reg;
        mod_next    = mod_reg;
        s_prev_next = s_prev_reg;
        s_cur_next  = s_cur_reg;
        prod_next   = prod_reg;
        x_next      = x_reg;
        inv_next    = inv_reg;
        st_next     = st_reg;
        out_next    = out_reg;
        rounds_next = rounds_reg;

        if (cmd.load)
        begin
            r_prev_next = in_data.value;
            r_cur_next  = in_data.modulus;
            mod_next    = in_data.modulus;
            s_prev_next = S_W'(1);
            s_cur_next  = '0;
            rounds_next = '0;
        end

        if (cmd.mul)
        begin
            prod_next = prod_full[S_W:0];
        end

        // Shift the remainder and coefficient pairs by one round.
        if (cmd.upd)
        begin
            r_prev_next = r_cur_reg;
            r_cur_next  = div_rem;
            s_prev_next = s_cur_reg;
            s_cur_next  = s_diff[S_W-1:0];
            rounds_next = rounds_reg + 1'b1;
        end

        // Decide the status and bring the coefficient into range once the loop has stopped.
        if (cmd.fin_norm)
        begin
            x_next = x_sum[DATA_W-1:0];
            if (mod_reg == '0)
            begin
                st_next = ST_MODZERO;
            end
            else if (r_cur_reg != '0 || r_prev_reg != DATA_W'(1))
            begin
                st_next = ST_NOINV;
            end
            else
            begin
                st_next = ST_OK;
            end
        end

        // Final reduction into 0..m-1; the inverse is zero on any failure.
        if (cmd.fin_fix)
        begin
            if (st_reg != ST_OK)
            begin
                inv_next = '0;
            end
            else if (x_reg >= mod_reg)
            begin
                inv_next = x_reg - mod_reg;
            end
            else
            begin
                inv_next = x_reg;
            end
        end

        if (cmd.result_load)
        begin
            out_next.inverse = inv_reg;
            out_next.status  = st_reg;
        end
    end

    // The round counter is control state; everything else is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_reg <= '0;
        end
        else
        begin
            rounds_reg <= rounds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_prev_reg <= r_prev_next;
        r_cur_reg  <= r_cur_next;
        mod_reg    <= mod_next;
        s_prev_reg <= s_prev_next;
        s_cur_reg  <= s_cur_next;
        prod_reg   <= prod_next;
        x_reg      <= x_next;
        inv_reg    <= inv_next;
        st_reg     <= st_next;
        out_reg    <= out_next;
    end

    assign stat.r_zero    = (r_cur_reg == '0);
    assign stat.div_busy  = div_busy;
    assign stat.round_max = (rounds_reg == ROUND_W'(ROUND_LIMIT));
    assign out_data       = out_reg;

endmodule

// ===== hdl/mie_ctrl.sv =====
module mie_ctrl
    import mie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   res_free;

    // The result register can take a new beat when empty or being drained.
    assign res_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.r_zero || stat.round_max)
                begin
                    state_next = S_FIN1;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_UPD;
            S_UPD:   state_next = S_CHECK;
            S_FIN1:  state_next = S_FIN2;
            S_FIN2:  state_next = S_DONE;
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_CHECK:
            begin
                cmd.div_start = !(stat.r_zero || stat.round_max);
            end
            S_MUL:   cmd.mul = 1'b1;
            S_UPD:   cmd.upd = 1'b1;
            S_FIN1:  cmd.fin_norm = 1'b1;
            S_FIN2:  cmd.fin_fix = 1'b1;
            S_DONE:  cmd.result_load = res_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/modular_inverse_ext_euclid_top.sv =====
// Modular inverse by the extended Euclidean algorithm. Each input beat carries a value and a
// modulus; one output beat returns the inverse in 0..m-1 with status 0, or inverse 0 with
// status 1 when the gcd is not one and status 2 when the modulus is zero. One item is
// worked at a time. Each Euclid round is a check state, a division on the shared restoring
// divider, which produces one quotient bit per cycle, then a multiply and an update state.
// The loop stops once the remainder is zero or after at most 72 rounds (ROUND_LIMIT); a zero
// modulus runs no round. The next input beat can be taken in the same cycle the result is
// first offered. A waiting result sits in an output register, so the next item is accepted
// while it is still to be taken.
module modular_inverse_ext_euclid_top
    import mie_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mie_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

// ===== hdl/mie_checker.sv =====
module mie_checker
    import mie_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // The status never carries the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK || out_data.status == ST_NOINV ||
                       out_data.status == ST_MODZERO))
        else $error("result status out of range");

    // Every failure reports an inverse of zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.inverse == '0)
        else $error("non-zero inverse with failing status");

    // A newly accepted item cannot produce a result in the very next cycle.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early after an accepted item");

endmodule

bind modular_inverse_ext_euclid_top mie_checker u_mie_checker (.*);
